[rtl/tefh_pkg.sv]
package tefh_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

  localparam int CNT_W        = 32;
  localparam int BYTES_W      = 480;
  localparam int BYTE_CNT_W   = 6;
  localparam int BEGIN_BYTES  = 8;
  localparam int EVENT_BYTES  = 60;

  localparam int QUEUE_DEPTH  = 2;
  localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic FUNC_BEGIN = 1'b0;
  localparam logic FUNC_EVENT = 1'b1;

  localparam logic [2:0] OP_BEGIN      = 3'd0;
  localparam logic [2:0] OP_BEGIN_DONE = 3'd1;
  localparam logic [2:0] OP_EVENT      = 3'd2;
  localparam logic [2:0] OP_EVENT_LAST = 3'd3;
  localparam logic [2:0] OP_ERROR      = 3'd4;

  typedef struct packed {
    logic        func;
    logic [7:0]  kind;
    logic [63:0] tick_stamp;
    logic [63:0] sequence_req;
    logic [31:0] address;
    logic [15:0] pc_value;
    logic [15:0] sp_value;
    logic [63:0] reg_state;
    logic [7:0]  data_value;
    logic [7:0]  auxiliary;
    logic [7:0]  cycle_index;
    logic [7:0]  tstate_count;
  } in_t;

  typedef struct packed {
    logic [63:0] hash;
    logic        done_res;
    logic        error;
  } out_t;

  // byte 0 of the stream sits in the low bits
  typedef struct packed {
    logic [2:0]         op;
    logic [BYTES_W-1:0] bytes;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

  // one fnv-1a step; the prime is 2^40 + 0x1b3, so the product is a sum of shifts
  function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

endpackage

[rtl/trace_event_fnv1a_hasher.sv]
// trace event fnv-1a hasher: 64-bit fingerprint over a run of trace events
// input channel (in_valid/in_ready/in_data): func 0 opens a run and folds in
// the event_count register as 8 bytes, func 1 folds in one event of 60 bytes
// output channel (out_valid/out_ready/out_data): hash with done_res at the end
// of a run (or at once for a zero count), error with hash 0 for an event that
// arrives with no open run; other transactions give no result
// cfg_we/cfg_data write event_count; it is sampled by the next begin
// a front end classifies each transaction and tracks the run, a two-entry
// queue holds the commands, and a back end folds one byte per cycle
// a begin or an event is loaded into the back end and then folded one byte
// at a time; the back end takes no new command until its last fold is done;
// an error goes straight to the output register; the result is registered
// on the last fold; the front accepts while the queue has space
// a stalled receiver holds the output register; the back end then waits on
// its final fold, the queue fills and in_ready drops
// reset clears the register, the run state, the queue and out_valid
module trace_event_fnv1a_hasher (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tefh_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tefh_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_data
);
  import tefh_pkg::*;

  hs_t  push_hs;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop;
  cmd_t pop_cmd;

  tefh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .push_hs    (push_hs),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  tefh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_hs    (push_hs),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  tefh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .pop       (pop),
    .cmd       (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/tefh_front.sv]
module tefh_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tefh_pkg::in_t          in_data,
  input  logic                   cfg_we,
  input  logic [31:0]            cfg_data,
  output tefh_pkg::hs_t          push_hs,
  input  logic                   push_ready,
  output tefh_pkg::cmd_t         push_cmd
);
  import tefh_pkg::*;

  logic [CNT_W-1:0] event_count;
  logic [CNT_W-1:0] events_left;
  logic [CNT_W-1:0] events_left_next;
  logic             run_open;
  logic             run_open_next;
  logic             accept;

  assign in_ready      = push_ready;
  assign accept        = in_valid && push_ready;
  assign push_hs.valid = in_valid;
  assign push_hs.ready = push_ready;

  always_comb begin
    push_cmd         = '0;
    events_left_next = events_left;
    run_open_next    = run_open;
    if (in_data.func == FUNC_BEGIN) begin
      push_cmd.bytes   = {{(BYTES_W-CNT_W){1'b0}}, event_count};
      push_cmd.op      = (event_count == '0) ? OP_BEGIN_DONE : OP_BEGIN;
      events_left_next = event_count;
      run_open_next    = (event_count != '0);
    end else if (!run_open) begin
      push_cmd.op = OP_ERROR;
    end else begin
      push_cmd.bytes = {in_data.tstate_count, in_data.cycle_index, in_data.auxiliary,
                        in_data.data_value, in_data.reg_state,
                        48'd0, in_data.sp_value, 48'd0, in_data.pc_value,
                        32'd0, in_data.address, in_data.sequence_req,
                        in_data.tick_stamp, 56'd0, in_data.kind};
      events_left_next = events_left - 1'b1;
      if (events_left == CNT_W'(1)) begin
        push_cmd.op   = OP_EVENT_LAST;
        run_open_next = 1'b0;
      end else begin
        push_cmd.op = OP_EVENT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_count <= '0;
      events_left <= '0;
      run_open    <= 1'b0;
    end else begin
      if (cfg_we) begin
        event_count <= cfg_data;
      end
      if (accept) begin
        events_left <= events_left_next;
        run_open    <= run_open_next;
      end
    end
  end

endmodule

[rtl/tefh_queue.sv]
module tefh_queue (
  input  logic           clk,
  input  logic           rst,
  input  tefh_pkg::hs_t  push_hs,
  output logic           push_ready,
  input  tefh_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop,
  output tefh_pkg::cmd_t pop_cmd
);
  import tefh_pkg::*;

  cmd_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_hs.valid && push_hs.ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/tefh_back.sv]
module tefh_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           pop,
  input  tefh_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output tefh_pkg::out_t out_data
);
  import tefh_pkg::*;

  logic                  busy;
  logic [2:0]            op;
  logic [BYTE_CNT_W-1:0] cnt;
  logic [BYTES_W-1:0]    shreg;
  logic [63:0]           hash;
  logic [63:0]           hash_next;
  logic                  out_free;
  logic                  emits;
  logic                  last;
  logic                  step;

  assign out_free  = !out_valid || out_ready;
  assign emits     = (op == OP_BEGIN_DONE) || (op == OP_EVENT_LAST);
  assign last      = (cnt == BYTE_CNT_W'(1));
  assign hash_next = fnv_fold(hash, shreg[7:0]);
  // the final fold waits until the output register can take the result
  assign step      = busy && (!last || !emits || out_free);
  assign pop       = cmd_valid && !busy && ((cmd.op != OP_ERROR) || out_free);

  always_ff @(posedge clk) begin
    if (pop && (cmd.op != OP_ERROR)) begin
      shreg <= cmd.bytes;
      op    <= cmd.op;
      cnt   <= ((cmd.op == OP_BEGIN) || (cmd.op == OP_BEGIN_DONE)) ?
               BYTE_CNT_W'(BEGIN_BYTES) : BYTE_CNT_W'(EVENT_BYTES);
    end else if (step) begin
      shreg <= shreg >> 8;
      cnt   <= cnt - 1'b1;
    end
    if (pop && ((cmd.op == OP_BEGIN) || (cmd.op == OP_BEGIN_DONE))) begin
      hash <= FNV_BASIS;
    end else if (step) begin
      hash <= hash_next;
    end
    if (pop && (cmd.op == OP_ERROR)) begin
      out_data <= '{hash: 64'd0, done_res: 1'b0, error: 1'b1};
    end else if (step && last && emits) begin
      out_data <= '{hash: hash_next, done_res: 1'b1, error: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && (cmd.op != OP_ERROR)) begin
        busy <= 1'b1;
      end else if (step && last) begin
        busy <= 1'b0;
      end
      if ((pop && (cmd.op == OP_ERROR)) || (step && last && emits)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/tefh_checker.sv]
module tefh_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input tefh_pkg::out_t out_data
);
  import tefh_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // a result is either a completed hash or an error, never both
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.done_res != out_data.error))
    else $error("done_res and error disagree");

  a_err_hash: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error |-> out_data.hash == 64'd0)
    else $error("error result carries a hash");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind trace_event_fnv1a_hasher tefh_checker u_tefh_checker (.*);

[bench/trace_event_fnv1a_hasher_tb.sv]
`timescale 1ns / 100ps

module trace_event_fnv1a_hasher_tb;
  import tefh_pkg::*;

  localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
  localparam int SETTLE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 810;
  localparam int STALL_CYCLES   = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;

  // predictor state, mirrors the block
  logic [31:0] count_copy = '0;
  logic [63:0] run_hash = FNV_BASIS;
  logic [31:0] events_pending = '0;
  logic        run_open = 1'b0;
  out_t        hash_results[$];

  int          items_sent = 0;
  int          fail_count = 0;
  int          hashes_checked = 0;
  int          errors_checked = 0;
  int          quiet_cycles = 0;
  int          hold_request = 0;
  logic        rx_hold = 1'b0;
  int          rx_gap = 0;
  int          rx_draw;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  out_t        want;

  trace_event_fnv1a_hasher uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] fnv_byte(input logic [63:0] h, input logic [7:0] b);
    return (h ^ {56'd0, b}) * FNV_PRIME;
  endfunction

  // eight bytes, least significant first
  function automatic logic [63:0] fnv_word(input logic [63:0] h, input logic [63:0] w);
    logic [63:0] acc;
    acc = h;
    for (int k = 0; k < 8; k++) acc = fnv_byte(acc, w[8*k +: 8]);
    return acc;
  endfunction

  function automatic void predict_run_result(input in_t it);
    logic [63:0] h;
    out_t r;
    r = '0;
    if (it.func == FUNC_BEGIN) begin
      run_hash = fnv_word(FNV_BASIS, {32'd0, count_copy});
      events_pending = count_copy;
      run_open = (count_copy != 0);
      if (!run_open) begin
        r.hash = run_hash;
        r.done_res = 1'b1;
        hash_results.push_back(r);
      end
    end else if (!run_open) begin
      r.error = 1'b1;
      hash_results.push_back(r);
    end else begin
      h = fnv_word(run_hash, {56'd0, it.kind});
      h = fnv_word(h, it.tick_stamp);
      h = fnv_word(h, it.sequence_req);
      h = fnv_word(h, {32'd0, it.address});
      h = fnv_word(h, {48'd0, it.pc_value});
      h = fnv_word(h, {48'd0, it.sp_value});
      h = fnv_word(h, it.reg_state);
      h = fnv_byte(h, it.data_value);
      h = fnv_byte(h, it.auxiliary);
      h = fnv_byte(h, it.cycle_index);
      h = fnv_byte(h, it.tstate_count);
      run_hash = h;
      events_pending = events_pending - 32'd1;
      if (events_pending == 0) begin
        run_open = 1'b0;
        r.hash = run_hash;
        r.done_res = 1'b1;
        hash_results.push_back(r);
      end
    end
  endfunction

  function automatic in_t random_item(input logic f);
    in_t it;
    it.func              = f;
    it.kind              = 8'($urandom);
    it.tick_stamp        = {$urandom, $urandom};
    it.sequence_req      = {$urandom, $urandom};
    it.address           = $urandom;
    it.pc_value          = 16'($urandom);
    it.sp_value          = 16'($urandom);
    it.reg_state         = {$urandom, $urandom};
    it.data_value        = 8'($urandom);
    it.auxiliary         = 8'($urandom);
    it.cycle_index       = 8'($urandom);
    it.tstate_count      = 8'($urandom);
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, exp_val);
    fail_count++;
  endtask

  // valid stays high between back-to-back items; this task only drops it for a gap
  task automatic send_item(input in_t it);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_run_result(it);
    items_sent++;
  endtask

  // wait for every result, then let the back end finish folds with no result
  task automatic drain();
    in_valid <= 1'b0;
    while (hash_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_event_count(input logic [31:0] value);
    cfg_data <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    count_copy = value;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (hash_results.size() == 0) begin
        report_mismatch("unexpected result, hash", out_data.hash, 64'd0);
      end else begin
        want = hash_results.pop_front();
        if (out_data.hash !== want.hash)
          report_mismatch("hash", out_data.hash, want.hash);
        if (out_data.done_res !== want.done_res)
          report_mismatch("done_res", 64'(out_data.done_res), 64'(want.done_res));
        if (out_data.error !== want.error)
          report_mismatch("error", 64'(out_data.error), 64'(want.error));
        if (want.error) errors_checked++;
        else hashes_checked++;
      end
    end
  end

  // receiver: a random pause after each transaction, or a long hold-off
  always @(posedge clk) begin
    if (rst || rx_hold) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      rx_draw = rx_idle ? $urandom_range(0, 3) : 0;
      rx_gap <= rx_draw;
      out_ready <= (rx_draw == 0);
    end else if (rx_gap != 0) begin
      rx_gap <= rx_gap - 1;
      out_ready <= (rx_gap == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        rx_hold <= 1'b1;
        repeat (hold_request) @(posedge clk);
        rx_hold <= 1'b0;
        hold_request = 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_event_without_run();
    in_t it;
    it = '0;
    it.func = FUNC_EVENT;
    send_item(it);
    it = '1;
    send_item(it);
  endtask

  task automatic test_zero_count_run();
    in_t it;
    drain();
    write_event_count(32'd0);
    it = '0;
    send_item(it);
    it = '1;
    it.func = FUNC_BEGIN;
    send_item(it);
  endtask

  task automatic test_single_event_runs();
    in_t it;
    drain();
    write_event_count(32'd1);
    send_item(random_item(FUNC_BEGIN));
    it = '1;
    send_item(it);
    send_item(random_item(FUNC_BEGIN));
    it = '0;
    it.func = FUNC_EVENT;
    send_item(it);
  endtask

  // a second begin throws the partial run away
  task automatic test_abandoned_run();
    drain();
    write_event_count(32'd3);
    send_item(random_item(FUNC_BEGIN));
    send_item(random_item(FUNC_EVENT));
    send_item(random_item(FUNC_BEGIN));
    repeat (3) send_item(random_item(FUNC_EVENT));
  endtask

  task automatic test_count_write_mid_run();
    drain();
    write_event_count(32'd2);
    send_item(random_item(FUNC_BEGIN));
    send_item(random_item(FUNC_EVENT));
    drain();
    write_event_count(32'd5);
    send_item(random_item(FUNC_EVENT));
    send_item(random_item(FUNC_EVENT));
    send_item(random_item(FUNC_BEGIN));
    repeat (5) send_item(random_item(FUNC_EVENT));
  endtask

  task automatic test_largest_count();
    drain();
    write_event_count(32'hffffffff);
    send_item(random_item(FUNC_BEGIN));
    repeat (2) send_item(random_item(FUNC_EVENT));
    drain();
    write_event_count(32'd1);
    send_item(random_item(FUNC_BEGIN));
    send_item(random_item(FUNC_EVENT));
  endtask

  // results pile up behind a stalled receiver until in_ready drops
  task automatic test_output_stall();
    drain();
    write_event_count(32'd0);
    hold_request = STALL_CYCLES;
    repeat (12) send_item(random_item(FUNC_BEGIN));
    drain();
  endtask

  task automatic random_run();
    logic [31:0] n;
    int unsigned cut;
    n = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 12 : 5);
    if (count_copy != 0 && count_copy <= 12 && $urandom_range(0, 1) == 0) begin
      n = count_copy;
    end else begin
      drain();
      write_event_count(n);
    end
    if ($urandom_range(0, 6) == 0) begin
      send_item(random_item(FUNC_BEGIN));
      cut = $urandom_range(0, n - 1);
      repeat (cut) send_item(random_item(FUNC_EVENT));
    end
    send_item(random_item(FUNC_BEGIN));
    repeat (n) send_item(random_item(FUNC_EVENT));
  endtask

  task automatic test_random_traffic();
    int start;
    int unsigned pick;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        random_run();
      end else if (pick < 75) begin
        // stray events need a closed run
        if (run_open) random_run();
        repeat ($urandom_range(1, 3)) send_item(random_item(FUNC_EVENT));
      end else if (pick < 85) begin
        drain();
        write_event_count(32'd0);
        repeat ($urandom_range(1, 4))
          send_item(random_item(($urandom_range(0, 2) == 0) ? FUNC_EVENT : FUNC_BEGIN));
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          drain();
          write_event_count(($urandom_range(0, 2) == 0) ? 32'hffffffff : $urandom);
        end
        repeat ($urandom_range(2, 8))
          send_item(random_item(($urandom_range(0, 3) == 0) ? FUNC_BEGIN : FUNC_EVENT));
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_event_without_run();
    test_zero_count_run();
    test_single_event_runs();
    test_abandoned_run();
    test_count_write_mid_run();
    test_largest_count();
    test_output_stall();
    test_random_traffic();
    drain();
    $display("%0d transactions sent, %0d hashes and %0d error results checked",
             items_sent, hashes_checked, errors_checked);
    $display("runs of up to twelve events, zero and largest counts, abandoned runs,");
    $display("stray events, a count change inside a run and a long output stall");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
